/* rtl/core/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared constants, codes and control types of the cluster chain engine.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int TABLE_ENTRIES = 65536;
    localparam int TBL_AW        = 16;
    localparam int LIMIT_W       = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(TABLE_ENTRIES);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] MIN_CLUSTER = LIMIT_W'(2);

    localparam logic [31:0] MASK28  = 32'h0FFF_FFFF;
    localparam logic [31:0] MASK16  = 32'h0000_FFFF;
    localparam logic [31:0] EOC28   = 32'h0FFF_FFF8;
    localparam logic [31:0] EOC16   = 32'h0000_FFF8;
    localparam logic [31:0] TOPBITS = 32'hF000_0000;

    // operation codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_SET    = 3'd1;
    localparam logic [2:0] OP_FOLLOW = 3'd2;
    localparam logic [2:0] OP_ALLOC  = 3'd3;
    localparam logic [2:0] OP_FREE   = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EOC     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // register index (paddr[2])
    localparam logic REG_WIDE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic start;
        logic step;
    } fcc_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } fcc_sts_t;

endpackage

/* rtl/core/fcc_ram.sv */
// ----------------------------------------------------------------------------
// fcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/fcc_ctrl.sv */
// ----------------------------------------------------------------------------
// fcc_ctrl
// Request sequencer: idle / evaluate state machine.
// ----------------------------------------------------------------------------
module fcc_ctrl import fcc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  fcc_sts_t sts,
    output fcc_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd.start = in_valid && in_ready;
    assign cmd.step  = (state_reg == S_EVAL) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (cmd.step && sts.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_start_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_EVAL))
        else $error("request accepted but no evaluation followed");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EVAL) && !sts.out_free) |=> (state_reg == S_EVAL))
        else $error("left evaluation while result slot was busy");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> !cmd.start)
        else $error("request accepted during evaluation");

endmodule

/* rtl/core/fcc_dp.sv */
// ----------------------------------------------------------------------------
// fcc_dp
// Datapath: request registers, entry decode, table write/read control and
// result register.
// ----------------------------------------------------------------------------
module fcc_dp import fcc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  fcc_cmd_t           cmd,
    output fcc_sts_t           sts,
    input  logic [2:0]         operation,
    input  logic [15:0]        cluster,
    input  logic [31:0]        value,
    input  logic               wide_entries,
    input  logic [LIMIT_W-1:0] limit_cfg,
    output logic               ram_we,
    output logic [TBL_AW-1:0]  ram_waddr,
    output logic [31:0]        ram_wdata,
    output logic               ram_re,
    output logic [TBL_AW-1:0]  ram_raddr,
    input  logic [31:0]        ram_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [15:0]        result_cluster,
    output logic [31:0]        entry_value
);

    logic [2:0]         op_reg;
    logic [31:0]        val_reg;
    logic [LIMIT_W-1:0] ptr_reg, ptr_next;
    logic [LIMIT_W-1:0] cnt_reg, cnt_next;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [15:0]        rc_reg;
    logic [31:0]        ev_reg;

    logic [LIMIT_W-1:0] lim;
    logic [31:0]        ent;
    logic               ent_eoc, ent_ok, ptr_ok;
    logic [31:0]        fill_word, clear_word, set_word;
    logic               last, we;
    logic [31:0]        wdata;
    logic [1:0]         st;
    logic [15:0]        rc;
    logic [31:0]        ev;

    // effective limit, saturated to table size
    assign lim = (limit_cfg > LIMIT_MAX) ? LIMIT_MAX : limit_cfg;

    assign ent     = ram_rdata & (wide_entries ? MASK28 : MASK16);
    assign ent_eoc = wide_entries ? (ent >= EOC28) : (ent >= EOC16);
    assign ent_ok  = (ent[31:LIMIT_W] == '0) && (ent[LIMIT_W-1:0] >= MIN_CLUSTER)
                     && (ent[LIMIT_W-1:0] < lim);
    assign ptr_ok  = (ptr_reg >= MIN_CLUSTER) && (ptr_reg < lim);

    assign fill_word  = wide_entries ? ((ram_rdata & TOPBITS) | MASK28) : MASK16;
    assign clear_word = wide_entries ? (ram_rdata & TOPBITS) : 32'd0;
    assign set_word   = wide_entries ? ((ram_rdata & TOPBITS) | (val_reg & MASK28))
                                     : (val_reg & MASK16);

    always_comb
    begin
        last     = 1'b1;
        we       = 1'b0;
        wdata    = 32'd0;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        st       = ST_OK;
        rc       = 16'd0;
        ev       = 32'd0;
        case (op_reg)
            OP_LOAD:
            begin
                we    = 1'b1;
                wdata = val_reg;
            end
            OP_SET:
            begin
                we    = 1'b1;
                wdata = set_word;
            end
            OP_FOLLOW:
            begin
                if (!ptr_ok)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    ev = ent;
                    if (ent_eoc)
                    begin
                        st = ST_EOC;
                    end
                    else if (!ent_ok)
                    begin
                        st = ST_INVALID;
                    end
                    else
                    begin
                        rc = ent[15:0];
                    end
                end
            end
            OP_ALLOC:
            begin
                if (ptr_reg >= lim)
                begin
                    st = ST_FULL;
                end
                else if (ent == 32'd0)
                begin
                    we    = 1'b1;
                    wdata = fill_word;
                    rc    = ptr_reg[15:0];
                end
                else
                begin
                    last     = 1'b0;
                    ptr_next = ptr_reg + LIMIT_W'(1);
                end
            end
            OP_FREE:
            begin
                if (!ptr_ok)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = clear_word;
                    cnt_next = cnt_reg + LIMIT_W'(1);
                    // a self link stops the walk: the read in the same cycle would return the old, uncleared entry
                    if (!(ent_eoc || !ent_ok || (ent[LIMIT_W-1:0] == ptr_reg)
                          || (cnt_next >= lim)))
                    begin
                        last     = 1'b0;
                        ptr_next = ent[LIMIT_W-1:0];
                    end
                end
            end
            OP_READ:
            begin
                ev = ent;
            end
            default:
            begin
                st = ST_INVALID;
            end
        endcase
    end

    assign sts.last     = last;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign ram_we    = cmd.step && we;
    assign ram_waddr = ptr_reg[TBL_AW-1:0];
    assign ram_wdata = wdata;
    assign ram_re    = cmd.start || (cmd.step && !last);
    assign ram_raddr = cmd.start ? ((operation == OP_ALLOC) ? MIN_CLUSTER[TBL_AW-1:0]
                                                            : cluster)
                                 : ptr_next[TBL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= operation;
            val_reg <= value;
            ptr_reg <= (operation == OP_ALLOC) ? MIN_CLUSTER : {1'b0, cluster};
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
        end
        if (cmd.step && last)
        begin
            status_reg <= st;
            rc_reg     <= rc;
            ev_reg     <= ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_cluster = rc_reg;
    assign entry_value    = ev_reg;

    a_we_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cmd.step && sts.out_free))
        else $error("table write outside an evaluation step");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.step && last))
        else $error("result appeared without a finishing step");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && last) |=> out_valid_reg)
        else $error("finishing step did not post a result");

endmodule

/* rtl/core/fat_cluster_chain_engine_core.sv */
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_core
// FAT16/FAT32 allocation table engine: load, set, follow, allocate, free
// chain and read on a 64K-entry table, with an APB register port.
// ----------------------------------------------------------------------------
// Sequencing: a request is accepted only in idle; its first table read is
//   issued at accept and used by the first evaluation step, which waits for
//   a free result slot. Load, set, follow, read and bad opcodes finish in
//   one step; allocate adds one step per occupied entry scanned from
//   cluster 2; free chain takes one step per link walked. A new request is
//   accepted only after the last step of the previous one.
// Reset: rst_n (async, low) clears the sequencer, result valid and registers
//   (FAT16 mode, limit 65536). Table contents are undefined until written.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_core import fcc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [15:0] cluster,
    input  logic [31:0] value,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] result_cluster,
    output logic [31:0] entry_value
);

    // config registers
    logic               wide_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr;

    // controller <-> datapath
    fcc_cmd_t cmd;
    fcc_sts_t sts;

    // table RAM port
    logic              ram_we;
    logic [TBL_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [TBL_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    // ------------------------------------------------------------------
    // APB: zero wait state; register index is paddr[2] (byte address 4*i).
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg  <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_WIDE:  wide_reg  <= pwdata[0];
                REG_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                default:   wide_reg  <= wide_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDE:  prdata = {31'd0, wide_reg};
            REG_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, limit_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: idle until a request, then evaluate steps until the
    // datapath flags the last one and the result slot is free.
    // ------------------------------------------------------------------
    fcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // ------------------------------------------------------------------
    // Datapath: decodes entries, scans for free clusters, walks chains
    // (one entry per step) and holds the result register, so a new request
    // is taken while the previous result waits downstream.
    // ------------------------------------------------------------------
    fcc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .operation      (operation),
        .cluster        (cluster),
        .value          (value),
        .wide_entries   (wide_reg),
        .limit_cfg      (limit_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_cluster (result_cluster),
        .entry_value    (entry_value)
    );

    // ------------------------------------------------------------------
    // Allocation table: 64K x 32, registered read.
    // ------------------------------------------------------------------
    fcc_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
